### hdl/dexs_pkg.sv
// ----------------------------------------------------------------------------
// dexs_pkg
// Shared types and constants for the determinant excitation and sign core.
// ----------------------------------------------------------------------------
package dexs_pkg;

	localparam int DATA_W  = 64;   // port width of one string word
	localparam int ORB_W   = 8;    // global orbital index width
	localparam int COUNT_W = 9;    // operator total width
	localparam int SUM_W   = 16;   // intermediate width for orbital sum

	localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

	typedef enum logic [1:0] {
		KIND_ANN = 2'd0,
		KIND_CRE = 2'd1,
		KIND_END = 2'd2
	} kind_t;

	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_RUN  = 1'b1
	} state_t;

	// sequencer strobes for one cycle of work
	typedef struct packed {
		logic go;       // sequencer advances this cycle
		logic emit;     // a result beat is loaded into the output register
		logic finish;   // the current word is done
	} seq_ctl_t;

	function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
		return (v == COUNT_MAX) ? v : v + COUNT_W'(1);
	endfunction

endpackage

### hdl/determinant_excitation_and_sign_core.sv
// ----------------------------------------------------------------------------
// determinant_excitation_and_sign_core
// Excitation operators and fermionic phase between two occupation strings.
// ----------------------------------------------------------------------------
// Each input beat carries one word of the source string (in_word) and the
// same word of the target string (out_word), lowest word first, with
// final_word on the last word. Bits set only in the source are annihilations,
// bits set only in the target are creations; each is sent out as one result
// beat with its global orbital index, in ascending order. A priority encoder
// peels one operator off the difference word per cycle unless the output
// register is stalled, and the block holds a word until it is done; in_stall
// is low while the block is idle and stays high from the cycle after the
// accept until the word is done.
// The phase is the parity, summed over all operators, of the common bits
// below each operator. The last beat of the final word carries vector_done,
// the phase and the annihilation and creation totals (saturating at 511);
// a final word with no difference yields a single end-marker beat. The last
// result beat of a word may wait in the output register while the next input
// beat is taken.
// ----------------------------------------------------------------------------
module determinant_excitation_and_sign_core
	import dexs_pkg::*;
#(
	parameter int WORD_BITS = 64,
	parameter int MAX_WORDS = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	// input channel
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [DATA_W-1:0]   in_word,
	input  logic [DATA_W-1:0]   out_word,
	input  logic                final_word,
	// result channel
	output logic                out_valid,
	input  logic                out_stall,
	output logic [1:0]          kind,
	output logic [ORB_W-1:0]    orbital,
	output logic                run_last,
	output logic                vector_done,
	output logic                phase,
	output logic [COUNT_W-1:0]  ann_total,
	output logic [COUNT_W-1:0]  cre_total
);

	localparam int IDX_W = $clog2(WORD_BITS);
	localparam int POS_W = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
	localparam logic [POS_W-1:0] POS_LAST = POS_W'(MAX_WORDS - 1);

	state_t state_q, state_d;
	seq_ctl_t ctl;

	// word under work
	logic [WORD_BITS-1:0] diff_q;
	logic [WORD_BITS-1:0] common_q;
	logic [WORD_BITS-1:0] src_q;      // source bits, tells annihilation from creation
	logic                 fin_q;

	// running string state
	logic [POS_W-1:0]     pos_q;
	logic                 cpar_q;     // parity of common bits in earlier words
	logic                 spar_q;     // sign parity
	logic [COUNT_W-1:0]   ann_q;
	logic [COUNT_W-1:0]   cre_q;

	// output register
	logic                 ovalid_q;
	kind_t                kind_q;
	logic [ORB_W-1:0]     orb_q;
	logic                 last_q;
	logic                 done_q;
	logic                 phase_q;
	logic [COUNT_W-1:0]   anntot_q;
	logic [COUNT_W-1:0]   cretot_q;

	// peel unit
	logic                 pk_found;
	logic [IDX_W-1:0]     pk_idx;
	logic                 pk_below;
	logic [WORD_BITS-1:0] pk_rest;

	dexs_peel #(
		.WORD_BITS(WORD_BITS)
	) u_peel (
		.diff   (diff_q),
		.common (common_q),
		.found  (pk_found),
		.idx    (pk_idx),
		.below  (pk_below),
		.rest   (pk_rest)
	);

	// per-operator values
	logic                 op_ann;
	logic                 op_last;
	logic                 spar_nx;
	logic [COUNT_W-1:0]   ann_nx;
	logic [COUNT_W-1:0]   cre_nx;
	logic [SUM_W-1:0]     orb_sum;
	logic                 slot_free;
	logic                 skip_word;  // non-final word with nothing to send

	assign op_ann    = |(src_q & diff_q & ~(diff_q - WORD_BITS'(1)));
	assign op_last   = ~|pk_rest;
	assign spar_nx   = spar_q ^ cpar_q ^ pk_below;
	assign ann_nx    = op_ann ? sat_inc(ann_q) : ann_q;
	assign cre_nx    = op_ann ? cre_q : sat_inc(cre_q);
	assign orb_sum   = SUM_W'(pos_q) * SUM_W'(WORD_BITS) + SUM_W'(pk_idx);
	assign slot_free = !ovalid_q || !out_stall;
	assign skip_word = !pk_found && !fin_q;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_RUN;
				end
			end
			ST_RUN: begin
				if (ctl.finish) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		ctl      = '0;
		in_stall = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
			end
			ST_RUN: begin
				ctl.go     = slot_free || skip_word;
				ctl.emit   = ctl.go && !skip_word;
				ctl.finish = ctl.go && (!pk_found || op_last);
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// word capture and peeling
	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			diff_q   <= in_word[WORD_BITS-1:0] ^ out_word[WORD_BITS-1:0];
			common_q <= in_word[WORD_BITS-1:0] & out_word[WORD_BITS-1:0];
			src_q    <= in_word[WORD_BITS-1:0];
			fin_q    <= final_word;
		end else if (ctl.emit) begin
			diff_q <= pk_rest;
		end
	end

	// string state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			cpar_q <= 1'b0;
			spar_q <= 1'b0;
			ann_q  <= '0;
			cre_q  <= '0;
		end else if (ctl.finish && fin_q) begin
			pos_q  <= '0;
			cpar_q <= 1'b0;
			spar_q <= 1'b0;
			ann_q  <= '0;
			cre_q  <= '0;
		end else begin
			if (ctl.emit && pk_found) begin
				spar_q <= spar_nx;
				ann_q  <= ann_nx;
				cre_q  <= cre_nx;
			end
			if (ctl.finish) begin
				cpar_q <= cpar_q ^ (^common_q);
				pos_q  <= (pos_q == POS_LAST) ? '0 : pos_q + POS_W'(1);
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (ctl.emit) begin
			ovalid_q <= 1'b1;
		end else if (!out_stall) begin
			ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.emit) begin
			if (pk_found) begin
				kind_q   <= op_ann ? KIND_ANN : KIND_CRE;
				orb_q    <= orb_sum[ORB_W-1:0];
				last_q   <= op_last;
				done_q   <= op_last && fin_q;
				phase_q  <= (op_last && fin_q) ? spar_nx : 1'b0;
				anntot_q <= (op_last && fin_q) ? ann_nx : '0;
				cretot_q <= (op_last && fin_q) ? cre_nx : '0;
			end else begin
				// final word with no difference: end marker
				kind_q   <= KIND_END;
				orb_q    <= '0;
				last_q   <= 1'b1;
				done_q   <= 1'b1;
				phase_q  <= spar_q;
				anntot_q <= ann_q;
				cretot_q <= cre_q;
			end
		end
	end

	assign out_valid   = ovalid_q;
	assign kind        = kind_q;
	assign orbital     = orb_q;
	assign run_last    = last_q;
	assign vector_done = done_q;
	assign phase       = phase_q;
	assign ann_total   = anntot_q;
	assign cre_total   = cretot_q;

endmodule

### hdl/dexs_peel.sv
// ----------------------------------------------------------------------------
// dexs_peel
// Peels the lowest set bit off the difference word: index, remainder, and
// parity of common bits below it.
// ----------------------------------------------------------------------------
module dexs_peel #(
	parameter int WORD_BITS = 64,
	localparam int IDX_W = $clog2(WORD_BITS)
) (
	input  logic [WORD_BITS-1:0] diff,
	input  logic [WORD_BITS-1:0] common,
	output logic                 found,
	output logic [IDX_W-1:0]     idx,
	output logic                 below,
	output logic [WORD_BITS-1:0] rest
);

	logic [WORD_BITS-1:0] low;
	logic [WORD_BITS-1:0] low_mask;

	assign low      = diff & (~diff + WORD_BITS'(1));
	assign low_mask = low - WORD_BITS'(1);
	assign rest     = diff & ~low;
	assign found    = |diff;
	assign below    = ^(common & low_mask);

	// one-hot to binary
	always_comb begin
		idx = '0;
		for (int i = 0; i < WORD_BITS; i++) begin
			if (low[i]) begin
				idx = idx | IDX_W'(i);
			end
		end
	end

endmodule

### hdl/dexs_checker.sv
// ----------------------------------------------------------------------------
// dexs_checker
// Port-level checks for the determinant excitation and sign core.
// ----------------------------------------------------------------------------
module dexs_checker
	import dexs_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input logic               out_valid,
	input logic               out_stall,
	input logic [1:0]         kind,
	input logic [ORB_W-1:0]   orbital,
	input logic               run_last,
	input logic               vector_done,
	input logic               phase,
	input logic [COUNT_W-1:0] ann_total,
	input logic [COUNT_W-1:0] cre_total
);

	// a held result beat keeps its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(kind) && $stable(orbital)
			&& $stable(run_last) && $stable(vector_done))
		else $error("result beat changed while stalled");

	// an accepted word keeps the block busy on the next cycle
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken twice in a row");

	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && vector_done |-> run_last)
		else $error("vector_done without run_last");

	a_end_marker: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == KIND_END |-> vector_done && orbital == '0)
		else $error("end marker malformed");

	a_totals_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !vector_done |-> !phase && ann_total == '0 && cre_total == '0)
		else $error("phase or totals set before vector_done");

endmodule

bind determinant_excitation_and_sign_core dexs_checker u_dexs_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_stall    (in_stall),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.kind        (kind),
	.orbital     (orbital),
	.run_last    (run_last),
	.vector_done (vector_done),
	.phase       (phase),
	.ann_total   (ann_total),
	.cre_total   (cre_total)
);
